@@ hdl/wosp_pkg.sv @@
// Package for the walk-on-spheres step unit.
// Holds the item structs, operation and register codes, and the sine coefficients.
// No dependencies.
package wosp_pkg;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         segment_slot;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic [15:0]        angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        radius;
    logic [7:0]         step_count;
    logic               finished;
  } out_item_t;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

  localparam int SEG_W = 128;
  localparam int MW    = 35;

  localparam logic [31:0] STOP_RESET = 32'd655;

  localparam logic signed [MW-1:0] SIN_C4 = 35'sd172274;
  localparam logic signed [MW-1:0] SIN_COEF [4] = '{
    35'sd5026995, 35'sd85569306, 35'sd693598669, 35'sd1686629713
  };

endpackage

@@ hdl/wosp_seg_mem.sv @@
// Segment table memory: one write port, one registered read port.
// Depends on wosp_pkg.
module wosp_seg_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [wosp_pkg::SEG_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [wosp_pkg::SEG_W-1:0] rd_data
);

  logic [wosp_pkg::SEG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/walk_on_spheres_step_unit.sv @@
// Walk-on-spheres step unit: top level with sequencer and shared multiplier.
// Depends on wosp_pkg and wosp_seg_mem.
//
// Channels: in (valid/ready, wosp_pkg::in_item_t), out (valid/ready,
// wosp_pkg::out_item_t), cfg (valid/ready, index + data; always ready).
// A load item writes one table slot; a start item sets the walk position.
// Neither gives a result.
// A step item scans segments 0..min(count,SEG_MAX)-1 for the least distance, evaluates
// cosine and sine of the angle, moves the position and gives one result.
// Each segment is worked on the shared 35x35 multiplier,
// restoring divider and bit-serial square root; trig and move follow.
// A step after the walk ended goes straight to the result.
// One item is in work at a time; in is ready again when the sequencer is idle.
// Reset: position 0, steps 0, walk ended, radius 0, stop_distance 655,
// segment_count 0. The table is not cleared.
// When out stalls, the finished result waits in the output register; the
// next item is accepted meanwhile, and a new result waits until it is taken.
module walk_on_spheres_step_unit #(
  parameter int SEG_MAX   = 256,
  parameter int MAX_STEPS = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  wosp_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output wosp_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wosp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int AW = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
  localparam int CW = $clog2(SEG_MAX + 1);
  localparam int MW = wosp_pkg::MW;
  localparam int PW = 2 * MW;

  typedef enum logic [28:0] {
    ST_IDLE  = 29'(1) << 0,
    ST_RD    = 29'(1) << 1,
    ST_DIFF  = 29'(1) << 2,
    ST_NUM1  = 29'(1) << 3,
    ST_NUM2  = 29'(1) << 4,
    ST_DEN1  = 29'(1) << 5,
    ST_DEN2  = 29'(1) << 6,
    ST_DSUM  = 29'(1) << 7,
    ST_CLASS = 29'(1) << 8,
    ST_DIV   = 29'(1) << 9,
    ST_CX    = 29'(1) << 10,
    ST_CY    = 29'(1) << 11,
    ST_EY    = 29'(1) << 12,
    ST_SQ1   = 29'(1) << 13,
    ST_SQ2   = 29'(1) << 14,
    ST_D2    = 29'(1) << 15,
    ST_SQRT  = 29'(1) << 16,
    ST_MIN   = 29'(1) << 17,
    ST_TSET  = 29'(1) << 18,
    ST_TX2   = 29'(1) << 19,
    ST_TX2R  = 29'(1) << 20,
    ST_TH    = 29'(1) << 21,
    ST_THS   = 29'(1) << 22,
    ST_TFIN  = 29'(1) << 23,
    ST_TRND  = 29'(1) << 24,
    ST_MVX   = 29'(1) << 25,
    ST_MVY   = 29'(1) << 26,
    ST_MVEND = 29'(1) << 27,
    ST_OUT   = 29'(1) << 28
  } state_t;

  state_t state;

  logic [31:0]        stop_distance;
  logic [8:0]         segment_count;
  logic signed [31:0] position_x, position_y;
  logic [7:0]         steps_taken;
  logic               walk_done;
  logic [31:0]        final_radius;

  logic [15:0]          ang;
  logic [CW-1:0]        k;
  logic [CW-1:0]        nseg;
  logic [31:0]          r;
  logic [31:0]          seg_dist;
  logic signed [31:0]   ax, ay;
  logic signed [MW-1:0] ux, uy, wx, wy, ex, ey;
  logic signed [PW-1:0] p, acc, num, den;
  logic [PW-1:0]        rem;
  logic [16:0]          t;
  logic [3:0]           cnt;
  logic [63:0]          sq_rem, sq_res, sq_bit;
  logic [16:0]          xx, x2;
  logic signed [MW-1:0] poly;
  logic [1:0]           hi;
  logic                 tneg, trig_sel;
  logic signed [17:0]   cosv, sinv;

  logic signed [MW-1:0] mul_a, mul_b;
  logic                 in_xfer;
  logic [wosp_pkg::SEG_W-1:0] rd_data;
  logic                 wr_en;

  logic signed [PW-1:0] sum_ap;
  logic [PW-1:0]        rem2;
  logic [64:0]          sq_try;
  logic [15:0]          tang;
  logic [16:0]          x16;
  logic [39:0]          s_raw;
  logic [17:0]          s_cap;
  logic signed [MW-1:0] mv_d;
  logic signed [35:0]   cxy_off;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return 32'(v);
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign wr_en     = in_xfer && (in_data.operation == wosp_pkg::OP_LOAD) &&
                     (32'(in_data.segment_slot) < SEG_MAX);
  assign nseg      = (32'(segment_count) > SEG_MAX) ? CW'(SEG_MAX) : CW'(segment_count);

  wosp_seg_mem #(.DEPTH(SEG_MAX), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.segment_slot)),
    .wr_data ({in_data.first_x, in_data.first_y, in_data.second_x, in_data.second_y}),
    .rd_addr (k[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_NUM1: begin mul_a = wx; mul_b = ux; end
      ST_NUM2: begin mul_a = wy; mul_b = uy; end
      ST_DEN1: begin mul_a = ux; mul_b = ux; end
      ST_DEN2: begin mul_a = uy; mul_b = uy; end
      ST_CX:   begin mul_a = MW'(t); mul_b = ux; end
      ST_CY:   begin mul_a = MW'(t); mul_b = uy; end
      ST_SQ1:  begin mul_a = ex; mul_b = ex; end
      ST_SQ2:  begin mul_a = ey; mul_b = ey; end
      ST_TX2:  begin mul_a = MW'(xx); mul_b = MW'(xx); end
      ST_TH:   begin mul_a = poly; mul_b = MW'(x2); end
      ST_TFIN: begin mul_a = poly; mul_b = MW'(xx); end
      ST_MVX:  begin mul_a = MW'(r); mul_b = MW'(cosv); end
      ST_MVY:  begin mul_a = MW'(r); mul_b = MW'(sinv); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    sum_ap  = acc + p;
    rem2    = {rem[PW-2:0], 1'b0};
    sq_try  = {1'b0, sq_res} + {1'b0, sq_bit};
    tang    = trig_sel ? ang : ang + 16'h4000;
    x16     = {1'b0, tang[13:0], 2'b00};
    s_raw   = (40'(p >>> 16) + 40'd8192) >> 14;
    s_cap   = (s_raw > 40'd65536) ? 18'd65536 : 18'(s_raw);
    mv_d    = MW'((p + 70'sd32768) >>> 16);
    cxy_off = 36'(p >>> 16);
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (rst) begin
      state         <= ST_IDLE;
      stop_distance <= wosp_pkg::STOP_RESET;
      segment_count <= '0;
      position_x    <= '0;
      position_y    <= '0;
      steps_taken   <= '0;
      walk_done     <= 1'b1;
      final_radius  <= '0;
      out_valid     <= 1'b0;
      trig_sel      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          wosp_pkg::CFG_STOP:  stop_distance <= cfg_data;
          wosp_pkg::CFG_COUNT: segment_count <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_data.operation == wosp_pkg::OP_START) begin
              position_x   <= in_data.first_x;
              position_y   <= in_data.first_y;
              steps_taken  <= '0;
              walk_done    <= 1'b0;
              final_radius <= '0;
            end else if (in_data.operation == wosp_pkg::OP_STEP) begin
              ang      <= in_data.angle;
              r        <= 32'hFFFFFFFF;
              k        <= '0;
              trig_sel <= 1'b0;
              if (walk_done) begin
                state <= ST_OUT;
              end else if (nseg == '0) begin
                state <= ST_TSET;
              end else begin
                state <= ST_RD;
              end
            end
          end
        end
        ST_RD: state <= ST_DIFF;
        ST_DIFF: begin
          ax <= rd_data[127:96];
          ay <= rd_data[95:64];
          ux <= MW'($signed(rd_data[63:32])) - MW'($signed(rd_data[127:96]));
          uy <= MW'($signed(rd_data[31:0]))  - MW'($signed(rd_data[95:64]));
          wx <= MW'(position_x) - MW'($signed(rd_data[127:96]));
          wy <= MW'(position_y) - MW'($signed(rd_data[95:64]));
          state <= ST_NUM1;
        end
        ST_NUM1: state <= ST_NUM2;
        ST_NUM2: begin acc <= p; state <= ST_DEN1; end
        ST_DEN1: begin num <= sum_ap; state <= ST_DEN2; end
        ST_DEN2: begin acc <= p; state <= ST_DSUM; end
        ST_DSUM: begin den <= sum_ap; state <= ST_CLASS; end
        ST_CLASS: begin
          priority if (den == '0 || num[PW-1] || num == '0) begin
            t     <= '0;
            state <= ST_CX;
          end else if (num >= den) begin
            t     <= 17'd65536;
            state <= ST_CX;
          end else begin
            t     <= '0;
            rem   <= num;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem2 >= den) begin
            rem <= rem2 - den;
            t   <= {t[15:0], 1'b1};
          end else begin
            rem <= rem2;
            t   <= {t[15:0], 1'b0};
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= ST_CX;
          end
        end
        ST_CX: state <= ST_CY;
        ST_CY: begin
          ex    <= MW'(36'(position_x) - 36'(ax) - cxy_off);
          state <= ST_EY;
        end
        ST_EY: begin
          ey    <= MW'(36'(position_y) - 36'(ay) - cxy_off);
          state <= ST_SQ1;
        end
        ST_SQ1: state <= ST_SQ2;
        ST_SQ2: begin acc <= p; state <= ST_D2; end
        ST_D2: begin
          if (sum_ap[PW-1:64] != '0) begin
            seg_dist <= 32'hFFFFFFFF;
            state    <= ST_MIN;
          end else begin
            sq_rem <= sum_ap[63:0];
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            state  <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if ({1'b0, sq_rem} >= sq_try) begin
            sq_rem <= sq_rem - sq_try[63:0];
            sq_res <= (sq_res >> 1) + sq_bit;
            if (sq_bit[0]) begin
              seg_dist <= 32'((sq_res >> 1) + sq_bit);
            end
          end else begin
            sq_res <= sq_res >> 1;
            if (sq_bit[0]) begin
              seg_dist <= 32'(sq_res >> 1);
            end
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (seg_dist < r) begin
            r <= seg_dist;
          end
          k <= k + CW'(1);
          if (k + CW'(1) == nseg) begin
            state <= ST_TSET;
          end else begin
            state <= ST_RD;
          end
        end
        ST_TSET: begin
          xx    <= tang[14] ? 17'd65536 - x16 : x16;
          tneg  <= tang[15];
          state <= ST_TX2;
        end
        ST_TX2: state <= ST_TX2R;
        ST_TX2R: begin
          x2    <= p[32:16];
          poly  <= wosp_pkg::SIN_C4;
          hi    <= '0;
          state <= ST_TH;
        end
        ST_TH: state <= ST_THS;
        ST_THS: begin
          poly <= wosp_pkg::SIN_COEF[hi] - MW'(p >>> 16);
          hi   <= hi + 2'd1;
          if (hi == 2'd3) begin
            state <= ST_TFIN;
          end else begin
            state <= ST_TH;
          end
        end
        ST_TFIN: state <= ST_TRND;
        ST_TRND: begin
          if (!trig_sel) begin
            cosv     <= tneg ? -$signed(s_cap) : $signed(s_cap);
            trig_sel <= 1'b1;
            state    <= ST_TSET;
          end else begin
            sinv  <= tneg ? -$signed(s_cap) : $signed(s_cap);
            state <= ST_MVX;
          end
        end
        ST_MVX: state <= ST_MVY;
        ST_MVY: begin
          position_x <= sat32(36'(position_x) + 36'(mv_d));
          state      <= ST_MVEND;
        end
        ST_MVEND: begin
          position_y   <= sat32(36'(position_y) + 36'(mv_d));
          steps_taken  <= steps_taken + 8'd1;
          final_radius <= r;
          walk_done    <= (r <= stop_distance) ||
                          ({1'b0, steps_taken} + 9'd1 >= 9'(MAX_STEPS));
          state        <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.pos_x      <= position_x;
            out_data.pos_y      <= position_y;
            out_data.radius     <= final_radius;
            out_data.step_count <= steps_taken;
            out_data.finished   <= walk_done;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_step_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.operation == wosp_pkg::OP_STEP) |=> state != ST_IDLE)
    else $error("step transfer did not start the sequencer");

  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!out_valid || out_ready)) |=> (out_valid && state == ST_IDLE))
    else $error("result not presented after sequencer finished");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (k < nseg))
    else $error("segment scan beyond segments in use");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.operation == wosp_pkg::OP_START) |=> (!walk_done && steps_taken == '0))
    else $error("start did not reset the walk");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for walk_on_spheres_step_unit.
// Drives segment loads, walk starts and steps under random idling and checks
// every result against a built-in predictor; depends on wosp_pkg and the RTL.
module testbench;

  localparam int NSEG = 256;
  localparam int STEP_LIMIT = 128;
  localparam int WATCHDOG_LIMIT = 400000;

  class walk_scoreboard;
    logic signed [31:0] seg_ax [NSEG];
    logic signed [31:0] seg_ay [NSEG];
    logic signed [31:0] seg_bx [NSEG];
    logic signed [31:0] seg_by [NSEG];
    logic [31:0] stop_dist;
    logic [8:0] seg_count;
    logic signed [31:0] walk_x, walk_y;
    logic [7:0] walk_steps;
    logic walk_ended;
    logic [31:0] last_radius;
    wosp_pkg::out_item_t pending [$];
    int errors;

    function new();
      stop_dist = wosp_pkg::STOP_RESET;
      seg_count = 0;
      walk_x = 0;
      walk_y = 0;
      walk_steps = 0;
      walk_ended = 1'b1;
      last_radius = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [wosp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == wosp_pkg::CFG_STOP) stop_dist = val;
      else if (idx == wosp_pkg::CFG_COUNT) seg_count = val[8:0];
    endfunction

    function logic [31:0] int_sqrt(logic [63:0] v);
      logic [63:0] rem, res, b;
      rem = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= res + b) begin
          rem = rem - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[31:0];
    endfunction

    function logic [31:0] seg_distance(longint px, longint py, int k);
      longint ax, ay, ux, uy, t, ex, ey;
      logic signed [127:0] wx, wy, sux, suy, num, den, sex, sey, d2;
      ax = seg_ax[k];
      ay = seg_ay[k];
      ux = longint'(seg_bx[k]) - ax;
      uy = longint'(seg_by[k]) - ay;
      wx = px - ax;
      wy = py - ay;
      sux = ux;
      suy = uy;
      num = wx * sux + wy * suy;
      den = sux * sux + suy * suy;
      if (den == 0 || num <= 0) t = 0;
      else if (num >= den) t = 65536;
      else t = longint'((num <<< 16) / den);
      ex = px - (ax + ((t * ux) >>> 16));
      ey = py - (ay + ((t * uy) >>> 16));
      sex = ex;
      sey = ey;
      d2 = sex * sex + sey * sey;
      if (d2[127:64] != 0) return 32'hFFFF_FFFF;
      return int_sqrt(d2[63:0]);
    endfunction

    function longint quarter_sine(logic [63:0] x);
      logic [63:0] x2, p, r;
      x2 = (x * x) >> 16;
      p = 64'd172274;
      p = 64'd5026995 - ((p * x2) >> 16);
      p = 64'd85569306 - ((p * x2) >> 16);
      p = 64'd693598669 - ((p * x2) >> 16);
      p = 64'd1686629713 - ((p * x2) >> 16);
      r = (((p * x) >> 16) + 64'd8192) >> 14;
      if (r > 64'd65536) r = 64'd65536;
      return longint'(r);
    endfunction

    function longint turn_sine(logic [15:0] a);
      logic [63:0] x;
      longint s;
      x = {48'd0, a[13:0], 2'b00};
      s = a[14] ? quarter_sine(64'd65536 - x) : quarter_sine(x);
      return a[15] ? -s : s;
    endfunction

    function logic signed [31:0] clamp_add(longint p, longint d);
      longint v;
      v = p + d;
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function void note_input(wosp_pkg::in_item_t it);
      int n;
      logic [31:0] r, d;
      longint c, s, px, py;
      wosp_pkg::out_item_t o;
      if (it.operation == wosp_pkg::OP_LOAD) begin
        seg_ax[it.segment_slot] = it.first_x;
        seg_ay[it.segment_slot] = it.first_y;
        seg_bx[it.segment_slot] = it.second_x;
        seg_by[it.segment_slot] = it.second_y;
      end else if (it.operation == wosp_pkg::OP_START) begin
        walk_x = it.first_x;
        walk_y = it.first_y;
        walk_steps = 0;
        walk_ended = 1'b0;
        last_radius = 0;
      end else if (it.operation == wosp_pkg::OP_STEP) begin
        if (!walk_ended) begin
          n = (seg_count > NSEG) ? NSEG : seg_count;
          r = 32'hFFFF_FFFF;
          px = walk_x;
          py = walk_y;
          for (int k = 0; k < n; k++) begin
            d = seg_distance(px, py, k);
            if (d < r) r = d;
          end
          c = turn_sine(it.angle + 16'h4000);
          s = turn_sine(it.angle);
          walk_x = clamp_add(px, (longint'(r) * c + 32768) >>> 16);
          walk_y = clamp_add(py, (longint'(r) * s + 32768) >>> 16);
          walk_steps = walk_steps + 8'd1;
          last_radius = r;
          walk_ended = (r <= stop_dist) || (walk_steps >= STEP_LIMIT);
        end
        o.pos_x = walk_x;
        o.pos_y = walk_y;
        o.radius = last_radius;
        o.step_count = walk_steps;
        o.finished = walk_ended;
        pending.insert(pending.size(), o);
      end
    endfunction

    function void check_result(wosp_pkg::out_item_t got);
      wosp_pkg::out_item_t exp_o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.pos_x !== exp_o.pos_x) begin
        $display("%0t: pos_x expected %0d actual %0d", $time, exp_o.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== exp_o.pos_y) begin
        $display("%0t: pos_y expected %0d actual %0d", $time, exp_o.pos_y, got.pos_y);
        errors++;
      end
      if (got.radius !== exp_o.radius) begin
        $display("%0t: radius expected %0d actual %0d", $time, exp_o.radius, got.radius);
        errors++;
      end
      if (got.step_count !== exp_o.step_count) begin
        $display("%0t: step_count expected %0d actual %0d", $time,
                 exp_o.step_count, got.step_count);
        errors++;
      end
      if (got.finished !== exp_o.finished) begin
        $display("%0t: finished expected %0b actual %0b", $time,
                 exp_o.finished, got.finished);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  wosp_pkg::in_item_t in_data;
  wosp_pkg::out_item_t out_data;
  logic [wosp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  walk_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;
  bit loaded [NSEG];

  walk_on_spheres_step_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_input(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic signed [31:0] coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $urandom;
    if (sel < 85) return $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    case ($urandom_range(0, 3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic wosp_pkg::in_item_t make_item(logic [1:0] op);
    wosp_pkg::in_item_t it;
    it.operation = op;
    it.segment_slot = 8'($urandom);
    it.first_x = coord();
    it.first_y = coord();
    it.second_x = coord();
    it.second_y = coord();
    it.angle = 16'($urandom);
    return it;
  endfunction

  task automatic send(wosp_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    if (it.operation == wosp_pkg::OP_LOAD) loaded[it.segment_slot] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [wosp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_upto(int n);
    wosp_pkg::in_item_t it;
    for (int k = 0; k < n && k < NSEG; k++) begin
      if (!loaded[k]) begin
        it = make_item(wosp_pkg::OP_LOAD);
        it.segment_slot = 8'(k);
        send(it);
      end
    end
  endtask

  task automatic run_phase(logic [31:0] stop_v, logic [8:0] count_v, int items);
    int sel;
    load_upto(count_v);
    drain();
    write_cfg(wosp_pkg::CFG_STOP, stop_v);
    write_cfg(wosp_pkg::CFG_COUNT, count_v);
    send(make_item(wosp_pkg::OP_START));
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) send(make_item(wosp_pkg::OP_LOAD));
      else if (sel < 18) send(make_item(wosp_pkg::OP_START));
      else if (sel < 96) send(make_item(wosp_pkg::OP_STEP));
      else send(make_item(wosp_pkg::OP_SPARE));
    end
  endtask

  initial begin
    wosp_pkg::in_item_t it;
    logic [31:0] stops [10];
    logic [8:0] counts [10];
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = wosp_pkg::CFG_STOP;
    cfg_data = 0;
    quiet_cycles = 0;
    send_idle_pct = 24;
    recv_idle_pct = 45;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // step before any start, unknown op, empty table walks
    send(make_item(wosp_pkg::OP_STEP));
    send(make_item(wosp_pkg::OP_SPARE));
    it = make_item(wosp_pkg::OP_START);
    it.first_x = 32'sh7FFF_FFFF;
    it.first_y = 32'sh8000_0000;
    send(it);
    foreach (stops[i]) stops[i] = 0;
    for (int a = 0; a < 5; a++) begin
      it = make_item(wosp_pkg::OP_STEP);
      it.angle = (a == 4) ? 16'hFFFF : 16'(a * 16'h4000);
      send(it);
      if (a == 1) begin
        it = make_item(wosp_pkg::OP_START);
        it.first_x = 0;
        it.first_y = 0;
        send(it);
      end
    end
    it = make_item(wosp_pkg::OP_LOAD);
    it.segment_slot = 0;
    it.first_x = 5 << 16;
    it.first_y = -(3 << 16);
    it.second_x = it.first_x;
    it.second_y = it.first_y;
    send(it);
    it = make_item(wosp_pkg::OP_LOAD);
    it.segment_slot = 1;
    it.first_x = 32'sh8000_0000;
    it.first_y = 32'sh8000_0000;
    it.second_x = 32'sh7FFF_FFFF;
    it.second_y = 32'sh7FFF_FFFF;
    send(it);
    it = make_item(wosp_pkg::OP_LOAD);
    it.segment_slot = 255;
    it.first_x = 32'sh7FFF_FFFF;
    it.first_y = 32'sh7FFF_FFFF;
    it.second_x = 32'sh8000_0000;
    it.second_y = 32'sh8000_0000;
    send(it);

    stops = '{32'd655, 32'd0, 32'hFFFF_FFFF, 32'd131072, 32'd1000,
              $urandom, 32'd655, 32'd40000, 32'd0, 32'd5000};
    counts = '{9'd2, 9'd1, 9'd3, 9'd8, 9'd5, 9'd4, 9'd6, 9'd12, 9'd2, 9'd3};
    for (int p = 0; p < 10; p++) begin
      if (p == 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 24;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(stops[p], counts[p], 120);
    end

    // full table and oversized counts
    run_phase(32'd655, 9'd256, 4);
    run_phase(32'd0, 9'd511, 3);
    run_phase(32'd655, 9'd300, 2);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
